/* hw/rtl/ske_pkg.sv */
package ske_pkg;

  localparam int unsigned MEAS_W    = 16;
  localparam int unsigned GAIN_W    = 17;
  localparam int unsigned QUO_W     = 16;
  localparam int unsigned ERR_W     = 32;
  localparam int unsigned DIVR_W    = ERR_W + 1;
  localparam int unsigned DIV_STEPS = QUO_W;
  localparam int unsigned CNT_W     = $clog2(DIV_STEPS);
  localparam int unsigned MUL_A_W   = 17;
  localparam int unsigned MUL_B_W   = 32;
  localparam int unsigned MUL_W     = MUL_A_W + MUL_B_W;
  localparam int unsigned APB_AW    = 4;
  localparam int unsigned APB_DW    = 32;

  localparam logic [GAIN_W-1:0] ONE_Q16    = 17'h1_0000;
  localparam logic [ERR_W-1:0]  MERR_RST   = 32'h0001_0000;
  localparam logic [ERR_W-1:0]  EERR_RST   = 32'h0001_0000;
  localparam logic [ERR_W-1:0]  PNOISE_RST = 32'd655;
  localparam logic [ERR_W-1:0]  ERR_MAX    = 32'hFFFF_FFFF;

  typedef enum logic [1:0] {
    REG_MERR   = 2'd0,
    REG_EERR   = 2'd1,
    REG_PNOISE = 2'd2
  } reg_idx_e;

  typedef enum logic [5:0] {
    ST_IDLE  = 6'b000001,
    ST_DIV   = 6'b000010,
    ST_STEP  = 6'b000100,
    ST_KEPT  = 6'b001000,
    ST_NOISE = 6'b010000,
    ST_DONE  = 6'b100000
  } ske_state_e;

  typedef struct packed {
    logic [ERR_W-1:0] meas_err;
    logic [ERR_W-1:0] proc_noise;
    logic             init_load;
    logic [ERR_W-1:0] init_val;
  } ske_cfg_t;

  typedef struct packed {
    logic             start;
    logic [ERR_W-1:0] dividend;
    logic [DIVR_W-1:0] divisor;
  } ske_div_req_t;

endpackage

/* hw/rtl/ske_if.sv */
interface ske_meas_if;
  logic                                valid;
  logic                                ready;
  logic signed [ske_pkg::MEAS_W-1:0]   measurement;

  modport source (output valid, output measurement, input ready);
  modport sink   (input valid, input measurement, output ready);
endinterface

interface ske_res_if;
  logic                                valid;
  logic                                ready;
  logic signed [ske_pkg::MEAS_W-1:0]   estimate;
  logic        [ske_pkg::GAIN_W-1:0]   gain;
  logic        [ske_pkg::ERR_W-1:0]    estimate_error;

  modport source (output valid, output estimate, output gain, output estimate_error,
                  input ready);
  modport sink   (input valid, input estimate, input gain, input estimate_error,
                  output ready);
endinterface

/* hw/rtl/scalar_kalman_estimator.sv */
// Scalar Kalman estimator: one signed Q8.8 measurement in, one result out (estimate, gain
// used, updated estimate error). An accepted sample goes through the 16-step radix-2 gain
// divide, then three passes through the single 17x32 multiplier, then a final state that waits
// for the result register to be free and loads it; the input is ready again only after that,
// so a new sample is taken only once the last one is through. Registers at byte
// offsets 0x0 (measurement error), 0x4 (initial estimate error, a write also reloads the
// running error) and 0x8 (process noise); write them only while no sample is in flight.
module scalar_kalman_estimator (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         psel,
  input  logic                         penable,
  input  logic                         pwrite,
  input  logic [ske_pkg::APB_AW-1:0]   paddr,
  input  logic [ske_pkg::APB_DW-1:0]   pwdata,
  output logic [ske_pkg::APB_DW-1:0]   prdata,
  output logic                         pready,
  ske_meas_if.sink                     meas_i,
  ske_res_if.source                    res_o
);

  ske_pkg::ske_cfg_t cfg;

  ske_regs u_regs (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg_o   (cfg)
  );

  ske_core u_core (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .cfg_i  (cfg),
    .meas_i (meas_i),
    .res_o  (res_o)
  );

endmodule

/* hw/rtl/ske_regs.sv */
module ske_regs (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         psel,
  input  logic                         penable,
  input  logic                         pwrite,
  input  logic [ske_pkg::APB_AW-1:0]   paddr,
  input  logic [ske_pkg::APB_DW-1:0]   pwdata,
  output logic [ske_pkg::APB_DW-1:0]   prdata,
  output logic                         pready,
  output ske_pkg::ske_cfg_t            cfg_o
);

  logic [ske_pkg::ERR_W-1:0] merr_q, eerr_q, pnoise_q;
  logic                      wr;
  ske_pkg::reg_idx_e         idx;

  assign pready = 1'b1;
  assign wr     = psel & penable & pwrite;
  assign idx    = ske_pkg::reg_idx_e'(paddr[3:2]);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      merr_q   <= ske_pkg::MERR_RST;
      eerr_q   <= ske_pkg::EERR_RST;
      pnoise_q <= ske_pkg::PNOISE_RST;
    end else if (wr) begin
      unique case (idx)
        ske_pkg::REG_MERR:   merr_q   <= pwdata;
        ske_pkg::REG_EERR:   eerr_q   <= pwdata;
        ske_pkg::REG_PNOISE: pnoise_q <= pwdata;
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (idx)
      ske_pkg::REG_MERR:   prdata = merr_q;
      ske_pkg::REG_EERR:   prdata = eerr_q;
      ske_pkg::REG_PNOISE: prdata = pnoise_q;
      default:             prdata = '0;
    endcase
  end

  // running error reloads on the same edge the register is written
  assign cfg_o.meas_err   = merr_q;
  assign cfg_o.proc_noise = pnoise_q;
  assign cfg_o.init_load  = wr && (idx == ske_pkg::REG_EERR);
  assign cfg_o.init_val   = pwdata;

endmodule

/* hw/rtl/ske_div.sv */
module ske_div (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  ske_pkg::ske_div_req_t       req_i,
  output logic                        done_o,
  output logic [ske_pkg::QUO_W-1:0]   quotient_o
);

  logic [ske_pkg::DIVR_W-1:0] rem_q, rem_d, div_q;
  logic [ske_pkg::QUO_W-1:0]  quo_q;
  logic [ske_pkg::CNT_W-1:0]  cnt_q;
  logic                       busy_q, done_q;
  logic [ske_pkg::DIVR_W:0]   shl, sub;
  logic                       ge;

  // restoring radix-2 on E << 16: E < divisor, so only 16 quotient bits
  always_comb begin
    shl   = {rem_q, 1'b0};
    sub   = shl - {1'b0, div_q};
    ge    = shl >= {1'b0, div_q};
    rem_d = ge ? sub[ske_pkg::DIVR_W-1:0] : shl[ske_pkg::DIVR_W-1:0];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (req_i.start) begin
        busy_q <= 1'b1;
        cnt_q  <= '0;
      end else if (busy_q) begin
        cnt_q <= cnt_q + 1'b1;
        if (cnt_q == ske_pkg::CNT_W'(ske_pkg::DIV_STEPS - 1)) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (req_i.start) begin
      rem_q <= {1'b0, req_i.dividend};
      div_q <= req_i.divisor;
      quo_q <= '0;
    end else if (busy_q) begin
      rem_q <= rem_d;
      quo_q <= {quo_q[ske_pkg::QUO_W-2:0], ge};
    end
  end

  assign done_o     = done_q;
  assign quotient_o = quo_q;

endmodule

/* hw/rtl/ske_core.sv */
module ske_core (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  ske_pkg::ske_cfg_t cfg_i,
  ske_meas_if.sink          meas_i,
  ske_res_if.source         res_o
);

  ske_pkg::ske_state_e state_q, state_d;

  logic signed [ske_pkg::MEAS_W-1:0]  meas_q, last_est_q, est_q, est_c;
  logic [ske_pkg::ERR_W-1:0]          err_q, kept_q, ne;
  logic [ske_pkg::MUL_W-1:0]          mul_q, mul;
  logic [ske_pkg::MUL_A_W-1:0]        op_a, d_q, d_c;
  logic [ske_pkg::MUL_B_W-1:0]        op_b;
  logic                               neg_q;

  logic signed [ske_pkg::MEAS_W:0]    diff;
  logic [ske_pkg::MEAS_W:0]           absdiff;
  logic [ske_pkg::ERR_W:0]            rnd;
  logic [ske_pkg::MEAS_W:0]           step;
  logic signed [ske_pkg::MEAS_W+1:0]  est_w, dd;
  logic [ske_pkg::MEAS_W+1:0]         absdd;
  logic [ske_pkg::MUL_W-9:0]          sum;
  logic [ske_pkg::ERR_W-1:0]          m_eff;

  ske_pkg::ske_div_req_t              div_req;
  logic                               div_done;
  logic [ske_pkg::QUO_W-1:0]          quo;

  logic                               in_fire, out_free;

  logic                               res_vld_q;
  logic signed [ske_pkg::MEAS_W-1:0]  res_est_q;
  logic [ske_pkg::GAIN_W-1:0]         res_gain_q;
  logic [ske_pkg::ERR_W-1:0]          res_err_q;

  assign meas_i.ready = (state_q == ske_pkg::ST_IDLE);
  assign in_fire      = meas_i.valid && meas_i.ready;
  assign out_free     = !res_vld_q || res_o.ready;

  // measurement error of zero is treated as one LSB
  assign m_eff            = (cfg_i.meas_err == '0) ? ske_pkg::ERR_W'(1) : cfg_i.meas_err;
  assign div_req.start    = in_fire;
  assign div_req.dividend = err_q;
  assign div_req.divisor  = {1'b0, err_q} + {1'b0, m_eff};

  ske_div u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .req_i      (div_req),
    .done_o     (div_done),
    .quotient_o (quo)
  );

  always_comb begin
    diff    = {meas_q[ske_pkg::MEAS_W-1], meas_q} - {last_est_q[ske_pkg::MEAS_W-1], last_est_q};
    absdiff = diff[ske_pkg::MEAS_W] ? ske_pkg::MEAS_W'(1) + ~diff : diff;
  end

  // shared multiplier; every product lands in mul_q before it is used
  always_comb begin
    unique case (state_q)
      ske_pkg::ST_STEP: begin
        op_a = {1'b0, quo};
        op_b = {{(ske_pkg::MUL_B_W - ske_pkg::MEAS_W - 1){1'b0}}, absdiff};
      end
      ske_pkg::ST_KEPT: begin
        op_a = ske_pkg::ONE_Q16 - {1'b0, quo};
        op_b = err_q;
      end
      ske_pkg::ST_NOISE: begin
        op_a = d_q;
        op_b = cfg_i.proc_noise;
      end
      default: begin
        op_a = '0;
        op_b = '0;
      end
    endcase
    mul = {{ske_pkg::MUL_B_W{1'b0}}, op_a} * {{ske_pkg::MUL_A_W{1'b0}}, op_b};
  end

  // round half away from zero on the magnitude, then clamp
  always_comb begin
    rnd   = {1'b0, mul_q[ske_pkg::ERR_W-1:0]} + (ske_pkg::ERR_W+1)'(32768);
    step  = rnd[ske_pkg::ERR_W:16];
    est_w = neg_q ? {{2{last_est_q[ske_pkg::MEAS_W-1]}}, last_est_q} - {1'b0, step}
                  : {{2{last_est_q[ske_pkg::MEAS_W-1]}}, last_est_q} + {1'b0, step};
    if (est_w > 18'sd32767)       est_c = 16'sh7FFF;
    else if (est_w < -18'sd32768) est_c = 16'sh8000;
    else                          est_c = est_w[ske_pkg::MEAS_W-1:0];
    dd    = {{2{last_est_q[ske_pkg::MEAS_W-1]}}, last_est_q}
          - {{2{est_c[ske_pkg::MEAS_W-1]}}, est_c};
    absdd = dd[ske_pkg::MEAS_W+1] ? (ske_pkg::MEAS_W+2)'(1) + ~dd : dd;
    d_c   = absdd[ske_pkg::MUL_A_W-1:0];
  end

  always_comb begin
    sum = {{(ske_pkg::MUL_W - 8 - ske_pkg::ERR_W){1'b0}}, kept_q}
        + mul_q[ske_pkg::MUL_W-1:8];
    ne  = (sum[ske_pkg::MUL_W-9:ske_pkg::ERR_W] != '0) ? ske_pkg::ERR_MAX
                                                        : sum[ske_pkg::ERR_W-1:0];
  end

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ske_pkg::ST_IDLE:  if (in_fire) state_d = ske_pkg::ST_DIV;
      ske_pkg::ST_DIV:   if (div_done) state_d = ske_pkg::ST_STEP;
      ske_pkg::ST_STEP:  state_d = ske_pkg::ST_KEPT;
      ske_pkg::ST_KEPT:  state_d = ske_pkg::ST_NOISE;
      ske_pkg::ST_NOISE: state_d = ske_pkg::ST_DONE;
      ske_pkg::ST_DONE:  if (out_free) state_d = ske_pkg::ST_IDLE;
      default:           state_d = ske_pkg::ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= ske_pkg::ST_IDLE;
      last_est_q <= '0;
      err_q      <= ske_pkg::EERR_RST;
      res_vld_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      if (cfg_i.init_load) begin
        err_q <= cfg_i.init_val;
      end else if (state_q == ske_pkg::ST_DONE && out_free) begin
        err_q <= ne;
      end
      if (state_q == ske_pkg::ST_DONE && out_free) begin
        last_est_q <= est_q;
        res_vld_q  <= 1'b1;
      end else if (res_o.ready) begin
        res_vld_q  <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_fire) meas_q <= meas_i.measurement;
    unique case (state_q)
      ske_pkg::ST_STEP: begin
        mul_q <= mul;
        neg_q <= diff[ske_pkg::MEAS_W];
      end
      ske_pkg::ST_KEPT: begin
        mul_q <= mul;
        est_q <= est_c;
        d_q   <= d_c;
      end
      ske_pkg::ST_NOISE: begin
        mul_q  <= mul;
        kept_q <= mul_q[ske_pkg::ERR_W+15:16];
      end
      ske_pkg::ST_DONE: begin
        if (out_free) begin
          res_est_q  <= est_q;
          res_gain_q <= {1'b0, quo};
          res_err_q  <= ne;
        end
      end
      default: ;
    endcase
  end

  assign res_o.valid          = res_vld_q;
  assign res_o.estimate       = res_est_q;
  assign res_o.gain           = res_gain_q;
  assign res_o.estimate_error = res_err_q;

  a_ready_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    meas_i.ready |-> state_q == ske_pkg::ST_IDLE)
    else $error("input ready outside idle");

  a_accept_div: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_fire |=> state_q == ske_pkg::ST_DIV)
    else $error("accepted sample did not start the divide");

  a_div_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    div_done |-> state_q == ske_pkg::ST_DIV)
    else $error("divider finished outside divide state");

  a_no_clamp: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == ske_pkg::ST_KEPT |-> (est_w <= 18'sd32767 && est_w >= -18'sd32768))
    else $error("estimate left Q8.8 range");

  a_gain_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_o.valid |-> !res_o.gain[ske_pkg::GAIN_W-1])
    else $error("gain reached one");

endmodule

/* dv/tb_scalar_kalman_estimator.sv */
`timescale 1ns / 100ps

module tb_scalar_kalman_estimator;

  localparam int unsigned SPARE_REG_IDX = 3;   // decodes to no register, write is dropped
  localparam int          HOLD_CYCLES   = 400;
  localparam int          STALL_LIMIT   = 4000;
  localparam int          TAIL_CYCLES   = 40;

  typedef struct packed {
    logic signed [ske_pkg::MEAS_W-1:0] estimate;
    logic [ske_pkg::GAIN_W-1:0]        gain;
    logic [ske_pkg::ERR_W-1:0]         estimate_error;
  } kf_result_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;

  logic                       psel = 1'b0;
  logic                       penable = 1'b0;
  logic                       pwrite = 1'b0;
  logic [ske_pkg::APB_AW-1:0] paddr = '0;
  logic [ske_pkg::APB_DW-1:0] pwdata = '0;
  logic [ske_pkg::APB_DW-1:0] prdata;
  logic                       pready;

  ske_meas_if meas_if ();
  ske_res_if  res_if ();

  scalar_kalman_estimator dut (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .meas_i  (meas_if),
    .res_o   (res_if)
  );

  always begin
    #1 clk_i = 1'b1;
    #1 clk_i = 1'b0;
  end

  // filter state and register shadow
  logic [ske_pkg::ERR_W-1:0]         meas_err_r   = ske_pkg::MERR_RST;
  logic [ske_pkg::ERR_W-1:0]         init_err_r   = ske_pkg::EERR_RST;
  logic [ske_pkg::ERR_W-1:0]         proc_noise_r = ske_pkg::PNOISE_RST;
  logic signed [ske_pkg::MEAS_W-1:0] last_est     = '0;
  logic [ske_pkg::ERR_W-1:0]         run_err      = ske_pkg::EERR_RST;

  logic signed [ske_pkg::MEAS_W-1:0] meas_pending_q[$];
  kf_result_t                        kf_result_q[$];

  int send_idle_pct = 0;
  int recv_idle_pct = 0;
  int hold_req = 0;
  int err_cnt = 0;
  int stall_cycles = 0;

  function automatic kf_result_t kalman_update(logic signed [ske_pkg::MEAS_W-1:0] meas);
    longint unsigned m, e, g, mag, d, kept, noise, ne;
    longint          diff, prod, stp, est;
    kf_result_t      r;
    m = (meas_err_r == '0) ? 64'd1 : 64'(meas_err_r);
    e = 64'(run_err);
    g = (e << 16) / (e + m);
    diff = longint'(meas) - longint'(last_est);
    prod = longint'(g) * diff;
    mag = (prod < 0) ? -prod : prod;
    stp = longint'((mag + 64'd32768) >> 16);
    if (prod < 0) stp = -stp;
    est = longint'(last_est) + stp;
    if (est > 32767) est = 32767;
    if (est < -32768) est = -32768;
    d = (longint'(last_est) > est) ? longint'(last_est) - est : est - longint'(last_est);
    kept = ((64'd65536 - g) * e) >> 16;
    noise = (d * 64'(proc_noise_r)) >> 8;
    ne = kept + noise;
    if (ne > 64'hFFFF_FFFF) ne = 64'hFFFF_FFFF;
    last_est = ske_pkg::MEAS_W'(est);
    run_err = ske_pkg::ERR_W'(ne);
    r.estimate = last_est;
    r.gain = ske_pkg::GAIN_W'(g);
    r.estimate_error = run_err;
    return r;
  endfunction

  // sample driver
  always @(posedge clk_i) begin
    logic fire;
    fire = meas_if.valid && meas_if.ready;
    if (!rst_ni) begin
      meas_if.valid <= 1'b0;
      meas_if.measurement <= '0;
    end else begin
      if (fire) begin
        kf_result_q.push_back(kalman_update(meas_if.measurement));
        void'(meas_pending_q.pop_front());
      end
      if (meas_if.valid && !fire) begin
        // hold the offered transaction
      end else if (meas_pending_q.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
        meas_if.valid <= 1'b1;
        meas_if.measurement <= meas_pending_q[0];
      end else begin
        meas_if.valid <= 1'b0;
        meas_if.measurement <= ske_pkg::MEAS_W'($urandom);
      end
    end
  end

  // result monitor and receiver backpressure
  always @(posedge clk_i) begin
    kf_result_t want;
    int hold_ack;
    int hold_left;
    if (!rst_ni) begin
      res_if.ready <= 1'b0;
      hold_ack = 0;
      hold_left = 0;
    end else begin
      if (res_if.valid && res_if.ready) begin
        if (kf_result_q.size() == 0) begin
          $display("%0t: unexpected result est %0d gain %0d err %0d", $time,
                   res_if.estimate, res_if.gain, res_if.estimate_error);
          err_cnt++;
        end else begin
          want = kf_result_q.pop_front();
          if (res_if.estimate !== want.estimate) begin
            $display("%0t: estimate exp %0d got %0d", $time, want.estimate, res_if.estimate);
            err_cnt++;
          end
          if (res_if.gain !== want.gain) begin
            $display("%0t: gain exp %0d got %0d", $time, want.gain, res_if.gain);
            err_cnt++;
          end
          if (res_if.estimate_error !== want.estimate_error) begin
            $display("%0t: estimate_error exp %0d got %0d", $time, want.estimate_error,
                     res_if.estimate_error);
            err_cnt++;
          end
        end
      end
      if (hold_ack != hold_req) begin
        hold_ack = hold_req;
        hold_left = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
        hold_left--;
        res_if.ready <= 1'b0;
      end else begin
        res_if.ready <= ($urandom_range(99) >= recv_idle_pct);
      end
    end
  end

  // watchdog: cycles without any transaction
  always @(posedge clk_i) begin
    if (!rst_ni || (meas_if.valid && meas_if.ready) || (res_if.valid && res_if.ready)) begin
      stall_cycles <= 0;
    end else if (stall_cycles >= STALL_LIMIT) begin
      $display("%0t: no progress for %0d cycles", $time, stall_cycles);
      $display("SCOREBOARD MISMATCH");
      $finish;
    end else begin
      stall_cycles <= stall_cycles + 1;
    end
  end

  task automatic reg_write(int unsigned idx, logic [ske_pkg::APB_DW-1:0] value);
    @(posedge clk_i);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= ske_pkg::APB_AW'(idx * 4);
    pwdata <= value;
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    while (!pready) @(posedge clk_i);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    case (idx)
      ske_pkg::REG_MERR:   meas_err_r = value;
      ske_pkg::REG_EERR: begin
        init_err_r = value;
        run_err = value;
      end
      ske_pkg::REG_PNOISE: proc_noise_r = value;
      default: ;
    endcase
  endtask

  task automatic drain();
    while (meas_pending_q.size() != 0 || kf_result_q.size() != 0) @(posedge clk_i);
  endtask

  // mostly a noisy signal around a level that now and then jumps, plus full-range and edge samples
  task automatic queue_random(int n);
    int level, v, pick;
    level = int'($urandom_range(65535)) - 32768;
    for (int i = 0; i < n; i++) begin
      if ($urandom_range(15) == 0) level = int'($urandom_range(65535)) - 32768;
      pick = $urandom_range(9);
      if (pick < 5) begin
        v = level + int'($urandom_range(1023)) - 512;
        if (v > 32767) v = 32767;
        if (v < -32768) v = -32768;
      end else if (pick < 8) begin
        v = int'($urandom_range(65535)) - 32768;
      end else begin
        case ($urandom_range(2))
          0: v = 32767;
          1: v = -32768;
          default: v = 0;
        endcase
      end
      meas_pending_q.push_back(ske_pkg::MEAS_W'(v));
    end
  endtask

  task automatic run_phase(int n, int s_pct, int r_pct, bit long_hold);
    send_idle_pct = s_pct;
    recv_idle_pct = r_pct;
    queue_random(n);
    if (long_hold) hold_req++;
    drain();
  endtask

  task automatic random_config();
    logic [ske_pkg::ERR_W-1:0] m;
    m = ($urandom_range(1) == 0) ? $urandom : ske_pkg::ERR_W'($urandom_range(1 << 20));
    reg_write(ske_pkg::REG_MERR, m);
    reg_write(ske_pkg::REG_EERR,
              ($urandom_range(1) == 0) ? $urandom : ske_pkg::ERR_W'($urandom_range(1 << 18)));
    reg_write(ske_pkg::REG_PNOISE,
              ($urandom_range(3) == 0) ? $urandom : ske_pkg::ERR_W'($urandom_range(4096)));
  endtask

  initial begin
    int dir_a[18] = '{0, 32767, -32768, 32767, -32768, 0, 1, -1, 21845, -21846,
                      256, -256, 100, 100, 100, 32512, -1, 0};
    meas_if.valid = 1'b0;
    meas_if.measurement = '0;
    res_if.ready = 1'b0;
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;

    // reset settings, edge samples first
    foreach (dir_a[i]) meas_pending_q.push_back(ske_pkg::MEAS_W'(dir_a[i]));
    run_phase(110, 13, 66, 1'b0);

    // zero measurement error is taken as one LSB; error and noise at max to saturate
    reg_write(ske_pkg::REG_MERR, '0);
    reg_write(ske_pkg::REG_EERR, ske_pkg::ERR_MAX);
    reg_write(ske_pkg::REG_PNOISE, ske_pkg::ERR_MAX);
    meas_pending_q.push_back(16'sh7FFF);
    meas_pending_q.push_back(16'sh8000);
    meas_pending_q.push_back(16'sh7FFF);
    meas_pending_q.push_back(16'sh8000);
    meas_pending_q.push_back(16'sh0000);
    meas_pending_q.push_back(16'sh7FFF);
    run_phase(100, 13, 66, 1'b1);

    // zero estimate error gives zero gain; largest measurement error
    reg_write(ske_pkg::REG_MERR, ske_pkg::ERR_MAX);
    reg_write(ske_pkg::REG_EERR, '0);
    reg_write(ske_pkg::REG_PNOISE, '0);
    meas_pending_q.push_back(16'sh7FFF);
    meas_pending_q.push_back(16'sh8000);
    meas_pending_q.push_back(16'sh0001);
    meas_pending_q.push_back(16'shFFFF);
    run_phase(100, 66, 13, 1'b0);

    reg_write(SPARE_REG_IDX, $urandom);
    reg_write(ske_pkg::REG_MERR, 32'd1);
    reg_write(ske_pkg::REG_EERR, ske_pkg::EERR_RST);
    reg_write(ske_pkg::REG_PNOISE, ske_pkg::PNOISE_RST);
    run_phase(100, 66, 13, 1'b0);

    random_config();
    run_phase(110, 0, 0, 1'b0);

    random_config();
    run_phase(110, 0, 0, 1'b0);

    repeat (TAIL_CYCLES) @(posedge clk_i);
    if (err_cnt == 0 && kf_result_q.size() == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule
